@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the checker file tsv_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, ignored while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/tsv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tsv_pkg;

  localparam int unsigned STAMP_W     = 64;
  localparam int unsigned GEN_W       = 64;
  localparam int unsigned US_W        = 54;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned MAX_AGE_W   = 63;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned REM_W       = 10;
  localparam int unsigned DIGIT_W     = 8;
  localparam int unsigned DIV_STAGES  = STAMP_W / DIGIT_W;
  localparam int unsigned MID_DEPTH   = 16;

  localparam logic [MAX_AGE_W-1:0] MAX_AGE_RESET = MAX_AGE_W'(100000000);
  localparam logic [REM_W:0]       US_DIVISOR    = (REM_W + 1)'(1000);
  localparam logic [62:0]          MIN_STAMP_NS  = 63'(1000);

  localparam logic [STATUS_W-1:0] ST_VALID   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DOMAIN  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_GEN     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STAMP   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STALE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FUTURE  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_REGRESS = 3'd6;

  typedef struct packed {
    logic signed [STAMP_W-1:0] measure_ns;
    logic signed [STAMP_W-1:0] publish_ns;
    logic                      domain_ok;
    logic [GEN_W-1:0]          gen_id;
  } item_t;

  typedef struct packed {
    logic                      ok;
    logic [STATUS_W-1:0]       status;
    logic [US_W-1:0]           measure_us;
    logic [US_W-1:0]           publish_us;
    logic signed [STAMP_W-1:0] age_ns;
    logic [GEN_W-1:0]          echo_gen;
    logic [CNT_W-1:0]          fail_total;
    logic [CNT_W-1:0]          regress_total;
  } result_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic signed [STAMP_W-1:0] meas;
    logic signed [STAMP_W-1:0] publ;
    logic [GEN_W-1:0]          gen;
    logic [STATUS_W-1:0]       status;
    logic signed [STAMP_W-1:0] age;
    logic [US_W-1:0]           meas_us;
    logic [US_W-1:0]           publ_us;
  } mid_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] q;
    logic [REM_W-1:0]   rem;
  } div_t;

  function automatic logic stamp_ok(logic [STAMP_W-1:0] v);
    return !v[STAMP_W-1] && (v[STAMP_W-2:0] >= MIN_STAMP_NS);
  endfunction

  // One digit of restoring division by 1000: eight narrow compare-subtract steps.
  function automatic div_t div_digit(logic [REM_W-1:0] rem_in, logic [DIGIT_W-1:0] digit);
    div_t           d;
    logic [REM_W:0] r;
    r = {1'b0, rem_in};
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      r = {r[REM_W-1:0], digit[i]};
      if (r >= US_DIVISOR) begin
        r = r - US_DIVISOR;
        d.q[i] = 1'b1;
      end else begin
        d.q[i] = 1'b0;
      end
    end
    d.rem = r[REM_W-1:0];
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/timestamp_pair_validator.sv @@
// Timestamp pair validator.
// Input side is a queue: drive item and raise push; the transaction completes at a
// rising edge with push high and full low. Result side is a queue too: while empty
// is low the oldest result sits on result; raise pop to take it.
// Each item yields exactly one result, in order: a status code, the echoed
// generation, both stamps in microseconds, the age, and the running failure and
// regression totals.
// Throughput: one item per cycle, sustained, as long as results are popped.
// Path: an accepted item is registered at the front, passes the eight-stage
// divide-by-1000 pipeline (one byte per stage), then the mid queue, the back
// (combinational) and the output queue, from which it is shown on result.
// If the receiver stalls, the output queue and the mid queue fill; full rises once
// MID_DEPTH transactions are in flight and drops again as results are taken.
// max_age_ns is written with cfg_we/cfg_wdata; write it only while the block is idle.
// rst (synchronous, active high) empties both queues and the pipeline, clears the
// stored reference stamps and both counters, and reloads max_age_ns to 100 ms.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_pair_validator #(
  parameter int unsigned MID_DEPTH = tsv_pkg::MID_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  tsv_pkg::item_t                item,
  output logic                          empty,
  input  logic                          pop,
  output tsv_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [tsv_pkg::MAX_AGE_W-1:0] cfg_wdata
);

  import tsv_pkg::*;

  logic [MAX_AGE_W-1:0] max_age_ns;
  logic                 front_valid;
  mid_t                 front_mid;
  mid_t                 queue_mid;
  logic                 mid_empty;
  logic                 take;
  logic                 out_full;
  result_t              back_res;

  // Hold the age limit; only cfg_we writes and rst move it.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_age_ns <= MAX_AGE_RESET;
    end else if (cfg_we) begin
      max_age_ns <= cfg_wdata;
    end
  end

  // Front: classify the stateless checks and divide both stamps by 1000.
  tsv_front #(
    .MID_DEPTH (MID_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .max_age_ns (max_age_ns),
    .drain      (take),
    .mid_valid  (front_valid),
    .mid        (front_mid)
  );

  // Decouple the front pipeline from the back; credits keep it from overflowing.
  tsv_fifo #(
    .WIDTH ($bits(mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_mid),
    .full  (),
    .pop   (take),
    .rdata (queue_mid),
    .empty (mid_empty)
  );

  // Back: regression check against the stored reference, counters, result build.
  tsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (!mid_empty),
    .mid       (queue_mid),
    .out_full  (out_full),
    .take      (take),
    .res       (back_res)
  );

  // Output queue: lets the back advance while a finished result waits for pop.
  tsv_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .wdata (back_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

`default_nettype wire

@@ rtl/core/tsv_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsv_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tsv_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsv_front #(
  parameter int unsigned MID_DEPTH = tsv_pkg::MID_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  tsv_pkg::item_t                    item,
  input  logic [tsv_pkg::MAX_AGE_W-1:0]     max_age_ns,
  input  logic                              drain,
  output logic                              mid_valid,
  output tsv_pkg::mid_t                     mid
);

  import tsv_pkg::*;

  typedef struct packed {
    logic signed [STAMP_W-1:0] meas;
    logic signed [STAMP_W-1:0] publ;
    logic [GEN_W-1:0]          gen;
    logic [STATUS_W-1:0]       status;
    logic signed [STAMP_W-1:0] age;
    logic [STAMP_W-1:0]        mq;
    logic [STAMP_W-1:0]        pq;
    logic [REM_W-1:0]          mrem;
    logic [REM_W-1:0]          prem;
  } stage_t;

  localparam int unsigned CW = $clog2(MID_DEPTH + 1);

  logic [CW-1:0]       credit;
  logic                accept;
  logic [STATUS_W-1:0] early_status;
  logic [DIV_STAGES:0] vld;
  stage_t              stg      [DIV_STAGES+1];
  stage_t              stg_next [DIV_STAGES+1];
  div_t                md       [DIV_STAGES];
  div_t                pd       [DIV_STAGES];
  logic signed [STAMP_W:0] age_x;
  logic signed [STAMP_W:0] lim_x;

  // Credits cover the pipeline plus the queue behind it, so the pipeline never stalls.
  assign full   = (credit == CW'(MID_DEPTH));
  assign accept = push && !full;

  always_comb begin
    if (!item.domain_ok) begin
      early_status = ST_DOMAIN;
    end else if (item.gen_id == '0) begin
      early_status = ST_GEN;
    end else if (!stamp_ok(item.measure_ns) || !stamp_ok(item.publish_ns)) begin
      early_status = ST_STAMP;
    end else begin
      early_status = ST_VALID;
    end
  end

  assign age_x = {stg[1].age[STAMP_W-1], stg[1].age};
  assign lim_x = $signed({2'b00, max_age_ns});

  always_comb begin
    stg_next[0].meas   = item.measure_ns;
    stg_next[0].publ   = item.publish_ns;
    stg_next[0].gen    = item.gen_id;
    stg_next[0].status = early_status;
    stg_next[0].age    = '0;
    stg_next[0].mq     = '0;
    stg_next[0].pq     = '0;
    stg_next[0].mrem   = '0;
    stg_next[0].prem   = '0;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      md[k-1] = div_digit(stg[k-1].mrem, stg[k-1].meas[(DIV_STAGES - k) * DIGIT_W +: DIGIT_W]);
      pd[k-1] = div_digit(stg[k-1].prem, stg[k-1].publ[(DIV_STAGES - k) * DIGIT_W +: DIGIT_W]);
      stg_next[k]      = stg[k-1];
      stg_next[k].mq   = {stg[k-1].mq[STAMP_W-DIGIT_W-1:0], md[k-1].q};
      stg_next[k].pq   = {stg[k-1].pq[STAMP_W-DIGIT_W-1:0], pd[k-1].q};
      stg_next[k].mrem = md[k-1].rem;
      stg_next[k].prem = pd[k-1].rem;
      if (k == 1) begin
        stg_next[k].age = stg[0].publ - stg[0].meas;
      end
      if (k == 2 && stg[1].status == ST_VALID) begin
        if (age_x > lim_x) begin
          stg_next[k].status = ST_STALE;
        end else if (age_x < -lim_x) begin
          stg_next[k].status = ST_FUTURE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= DIV_STAGES; k++) begin
      stg[k] <= stg_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      credit <= '0;
    end else begin
      vld <= {vld[DIV_STAGES-1:0], accept};
      if (accept && !drain) begin
        credit <= credit + 1'b1;
      end else if (drain && !accept) begin
        credit <= credit - 1'b1;
      end
    end
  end

  assign mid_valid   = vld[DIV_STAGES];
  assign mid.meas    = stg[DIV_STAGES].meas;
  assign mid.publ    = stg[DIV_STAGES].publ;
  assign mid.gen     = stg[DIV_STAGES].gen;
  assign mid.status  = stg[DIV_STAGES].status;
  assign mid.age     = stg[DIV_STAGES].age;
  assign mid.meas_us = stg[DIV_STAGES].mq[US_W-1:0];
  assign mid.publ_us = stg[DIV_STAGES].pq[US_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/tsv_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsv_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              mid_valid,
  input  tsv_pkg::mid_t     mid,
  input  logic              out_full,
  output logic              take,
  output tsv_pkg::result_t  res
);

  import tsv_pkg::*;

  logic                      have_last;
  logic [GEN_W-1:0]          last_gen;
  logic signed [STAMP_W-1:0] last_measure;
  logic signed [STAMP_W-1:0] last_publish;
  logic [CNT_W-1:0]          fail_count;
  logic [CNT_W-1:0]          regress_count;
  logic [CNT_W-1:0]          fail_count_next;
  logic [CNT_W-1:0]          regress_count_next;
  logic                      regress;
  logic                      pass;
  logic [STATUS_W-1:0]       status;

  assign take = mid_valid && !out_full;

  assign regress = (mid.status == ST_VALID) && have_last && (last_gen == mid.gen)
                   && ((mid.meas < last_measure) || (mid.publ < last_publish));
  assign status  = regress ? ST_REGRESS : mid.status;
  assign pass    = (status == ST_VALID);

  assign fail_count_next    = (!pass && fail_count != '1) ? fail_count + 1'b1 : fail_count;
  assign regress_count_next = (regress && regress_count != '1) ? regress_count + 1'b1
                                                               : regress_count;

  always_comb begin
    res.ok            = pass;
    res.status        = status;
    res.measure_us    = pass ? mid.meas_us : '0;
    res.publish_us    = pass ? mid.publ_us : '0;
    res.age_ns        = pass ? mid.age : '0;
    res.echo_gen      = mid.gen;
    res.fail_total    = fail_count_next;
    res.regress_total = regress_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last     <= 1'b0;
      last_gen      <= '0;
      last_measure  <= '0;
      last_publish  <= '0;
      fail_count    <= '0;
      regress_count <= '0;
    end else if (take) begin
      fail_count    <= fail_count_next;
      regress_count <= regress_count_next;
      if (pass) begin
        have_last    <= 1'b1;
        last_gen     <= mid.gen;
        last_measure <= mid.meas;
        last_publish <= mid.publ;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tsv_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tsv_checker (
  input logic             clk,
  input logic             rst,
  input logic             empty,
  input logic             pop,
  input tsv_pkg::result_t result
);

  import tsv_pkg::*;

  `ASSERT_ALWAYS(a_empty_after_reset, rst |=> empty, "result queue not empty after reset")
  `ASSERT_CLK(a_hold_result, !empty && !pop |=> !empty && $stable(result), "waiting result moved")
  `ASSERT_CLK(a_ok_matches_status, !empty |-> (result.ok == (result.status == ST_VALID)), "ok and status disagree")
  `ASSERT_CLK(a_reject_zeroed, !empty && !result.ok |-> (result.age_ns == '0) && (result.measure_us == '0) && (result.publish_us == '0), "rejected result carries data")
  `ASSERT_CLK(a_regress_within_fail, !empty |-> (result.regress_total <= result.fail_total), "regression total exceeds failure total")

endmodule

bind timestamp_pair_validator tsv_checker u_tsv_checker (.*);

`default_nettype wire
